// File: design/bba_pkg.sv
// Shared constants, types and helper functions for the block bitmap allocator.
package bba_pkg;

    localparam int NUM_BLOCKS       = 1024;
    localparam int NUM_INODES       = 64;
    localparam int DIRECT_PER_INODE = 12;

    localparam int MAP_BITS   = 64;
    localparam int MAP_WORDS  = NUM_BLOCKS / MAP_BITS;
    localparam int BIT_AW     = $clog2(MAP_BITS);
    localparam int WORD_AW    = $clog2(MAP_WORDS);
    localparam int BLK_W      = 10;
    localparam int INODE_W    = 6;
    localparam int LEN_W      = 4;
    localparam int IDX_W      = 4;
    localparam int LIST_DEPTH = NUM_INODES * DIRECT_PER_INODE;
    localparam int LIST_AW    = $clog2(LIST_DEPTH);

    localparam logic [2:0] CMD_ALLOC      = 3'd0;
    localparam logic [2:0] CMD_FREE       = 3'd1;
    localparam logic [2:0] CMD_TEST       = 3'd2;
    localparam logic [2:0] CMD_ALLOC_INO  = 3'd3;
    localparam logic [2:0] CMD_FREE_INO   = 3'd4;
    localparam logic [2:0] CMD_GET_INO    = 3'd5;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NO_FREE      = 3'd1;
    localparam logic [2:0] ST_BAD_BLOCK    = 3'd2;
    localparam logic [2:0] ST_INODE_UNUSED = 3'd3;
    localparam logic [2:0] ST_INODE_FULL   = 3'd4;
    localparam logic [2:0] ST_BAD_INDEX    = 3'd5;

    typedef struct packed {
        logic [MAP_BITS-1:0] word;
        logic [BIT_AW-1:0]   pos;
        logic                find_zero;
        logic                set_val;
    } word_req_t;

    typedef struct packed {
        logic                has_zero;
        logic [BIT_AW-1:0]   zero_pos;
        logic                bit_val;
        logic [MAP_BITS-1:0] new_word;
    } word_rsp_t;

    function automatic logic [MAP_BITS-1:0] map_reset_word(input logic [WORD_AW-1:0] w);
        logic [MAP_BITS-1:0] r;
        r = '0;
        if (w == '0)
        begin
            r[0] = 1'b1;
        end
        return r;
    endfunction

    function automatic logic block_ok(input logic [BLK_W-1:0] b);
        return (b != '0) && ({1'b0, b} < (BLK_W + 1)'(NUM_BLOCKS));
    endfunction

endpackage

// File: design/block_bitmap_allocator_core.sv
// Top level of the block bitmap allocator: request sequencer, state memories and result register.
//
// Usage: a request word enters on in_valid/in_stall with cmd, block_number, inode_number,
// inode_in_use and list_index; it is accepted on a rising edge with in_valid high and
// in_stall low. Exactly one result word leaves on out_valid/out_stall with status,
// block_result, is_used and free_count, taken on an edge with out_valid high and
// out_stall low. One request is worked on at a time and in_stall stays high until its
// result has been loaded into the output register.
// Steps: every request passes S_DISPATCH and ends in S_FINISH; a bad block, an unused
// inode or an unknown command go straight to S_FINISH, free and test use the bitmap bit in
// S_MAP_WAIT, inode commands read the list length in S_LEN_WAIT and a lookup takes the
// list entry in S_GET_WAIT. Allocation scans the bitmap one 64-bit word per cycle through the
// shared word unit in S_SCAN, from word 0 up to the lowest free block. Freeing all blocks
// of an inode reads each list entry in S_FA_WAIT and, for a valid block, its bitmap word
// in S_FA_MAP_WAIT. in_stall falls as out_valid rises.
// Reset clears out_valid and the sequencer, sets the internal free counter to
// NUM_BLOCKS - 1 and marks only block 0 used; bitmap rows and list lengths read as
// their reset values through valid bits until first written, so no clearing pass runs.
// When the receiver stalls, the result holds in the output register; the next request
// may be accepted and worked on, but it finishes only after that result is taken.
module block_bitmap_allocator_core
    import bba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         cmd,
    input  logic [BLK_W-1:0]   block_number,
    input  logic [INODE_W-1:0] inode_number,
    input  logic               inode_in_use,
    input  logic [IDX_W-1:0]   list_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [BLK_W-1:0]   block_result,
    output logic               is_used,
    output logic [BLK_W-1:0]   free_count
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LEN_WAIT,
        S_SCAN,
        S_MAP_WAIT,
        S_GET_WAIT,
        S_FA_WAIT,
        S_FA_MAP_WAIT,
        S_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [2:0]           cmd_reg, cmd_next;
    logic [BLK_W-1:0]     blk_reg, blk_next;
    logic [INODE_W-1:0]   ino_reg, ino_next;
    logic                 inuse_reg, inuse_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [LIST_AW-1:0]   base_reg, base_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [WORD_AW-1:0]   chk_reg, chk_next;
    logic [LEN_W-1:0]     iter_reg, iter_next;
    logic [BLK_W-1:0]     count_reg, count_next;
    logic [2:0]           res_status_reg, res_status_next;
    logic [BLK_W-1:0]     res_block_reg, res_block_next;
    logic                 res_used_reg, res_used_next;
    logic                 out_valid_reg, out_valid_next;
    logic [2:0]           status_reg, status_next;
    logic [BLK_W-1:0]     block_reg, block_next;
    logic                 used_reg, used_next;
    logic [BLK_W-1:0]     free_reg, free_next;
    logic [MAP_WORDS-1:0] map_valid_reg, map_valid_next;
    logic [NUM_INODES-1:0] len_valid_reg, len_valid_next;

    logic                 map_we;
    logic [WORD_AW-1:0]   map_waddr;
    logic [MAP_BITS-1:0]  map_wdata;
    logic [WORD_AW-1:0]   map_raddr;
    logic [MAP_BITS-1:0]  map_rdata;
    logic                 len_we;
    logic [LEN_W-1:0]     len_wdata;
    logic [LEN_W-1:0]     len_rdata;
    logic                 list_we;
    logic [LIST_AW-1:0]   list_waddr;
    logic [BLK_W-1:0]     list_wdata;
    logic [LIST_AW-1:0]   list_raddr;
    logic [BLK_W-1:0]     list_rdata;

    logic [WORD_AW-1:0]   word_idx;
    word_req_t            word_req;
    word_rsp_t            word_rsp;
    logic [LEN_W-1:0]     len_eff;
    logic                 ino_ok;
    logic                 fa_last;
    logic                 in_accept;

    bba_ram #(.WIDTH(MAP_BITS), .DEPTH(MAP_WORDS)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    bba_ram #(.WIDTH(LEN_W), .DEPTH(NUM_INODES)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (ino_reg),
        .wdata (len_wdata),
        .raddr (ino_reg),
        .rdata (len_rdata)
    );

    bba_ram #(.WIDTH(BLK_W), .DEPTH(LIST_DEPTH)) u_list_ram (
        .clk   (clk),
        .we    (list_we),
        .waddr (list_waddr),
        .wdata (list_wdata),
        .raddr (list_raddr),
        .rdata (list_rdata)
    );

    bba_word_unit u_word_unit (
        .req (word_req),
        .rsp (word_rsp)
    );

    assign in_stall     = (state_reg != S_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign block_result = block_reg;
    assign is_used      = used_reg;
    assign free_count   = free_reg;

    assign word_idx = (state_reg == S_SCAN) ? chk_reg : blk_reg[BLK_W-1 -: WORD_AW];
    assign len_eff  = len_valid_reg[ino_reg] ? len_rdata : '0;
    assign ino_ok   = inuse_reg && ({1'b0, ino_reg} < (INODE_W + 1)'(NUM_INODES));
    assign fa_last  = ({1'b0, iter_reg} + (LEN_W + 1)'(1)) >= {1'b0, len_reg};

    always_comb
    begin
        word_req.word      = map_valid_reg[word_idx] ? map_rdata : map_reset_word(word_idx);
        word_req.pos       = blk_reg[BIT_AW-1:0];
        word_req.find_zero = (state_reg == S_SCAN);
        word_req.set_val   = (state_reg == S_SCAN);
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        blk_next        = blk_reg;
        ino_next        = ino_reg;
        inuse_next      = inuse_reg;
        idx_next        = idx_reg;
        base_next       = base_reg;
        len_next        = len_reg;
        chk_next        = chk_reg;
        iter_next       = iter_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_block_next  = res_block_reg;
        res_used_next   = res_used_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        block_next      = block_reg;
        used_next       = used_reg;
        free_next       = free_reg;
        map_valid_next  = map_valid_reg;
        len_valid_next  = len_valid_reg;

        map_we     = 1'b0;
        map_waddr  = word_idx;
        map_wdata  = word_rsp.new_word;
        map_raddr  = '0;
        len_we     = 1'b0;
        len_wdata  = '0;
        list_we    = 1'b0;
        list_waddr = base_reg + LIST_AW'(len_reg);
        list_wdata = {chk_reg, word_rsp.zero_pos};
        list_raddr = base_reg + LIST_AW'(iter_reg);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    cmd_next   = cmd;
                    blk_next   = block_number;
                    ino_next   = inode_number;
                    inuse_next = inode_in_use;
                    idx_next   = list_index;
                    base_next  = LIST_AW'(inode_number * DIRECT_PER_INODE);
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                res_status_next = ST_OK;
                res_block_next  = '0;
                res_used_next   = 1'b0;
                chk_next        = '0;
                iter_next       = '0;
                map_raddr       = '0;
                state_next      = S_FINISH;
                case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        state_next = S_SCAN;
                    end
                    CMD_FREE, CMD_TEST:
                    begin
                        map_raddr = blk_reg[BLK_W-1 -: WORD_AW];
                        if ((cmd_reg == CMD_FREE) ? !block_ok(blk_reg)
                                : ({1'b0, blk_reg} >= (BLK_W + 1)'(NUM_BLOCKS)))
                        begin
                            res_status_next = ST_BAD_BLOCK;
                        end
                        else
                        begin
                            state_next = S_MAP_WAIT;
                        end
                    end
                    CMD_ALLOC_INO, CMD_FREE_INO, CMD_GET_INO:
                    begin
                        if (!ino_ok)
                        begin
                            res_status_next = ST_INODE_UNUSED;
                        end
                        else
                        begin
                            state_next = S_LEN_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_LEN_WAIT:
            begin
                len_next   = len_eff;
                state_next = S_FINISH;
                case (cmd_reg)
                    CMD_ALLOC_INO:
                    begin
                        map_raddr = '0;
                        if ({1'b0, len_eff} >= (LEN_W + 1)'(DIRECT_PER_INODE))
                        begin
                            res_status_next = ST_INODE_FULL;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    CMD_FREE_INO:
                    begin
                        list_raddr = base_reg;
                        if (len_eff == '0)
                        begin
                            len_we                  = 1'b1;
                            len_valid_next[ino_reg] = 1'b1;
                        end
                        else
                        begin
                            state_next = S_FA_WAIT;
                        end
                    end
                    CMD_GET_INO:
                    begin
                        list_raddr = base_reg + LIST_AW'(idx_reg);
                        if (idx_reg >= len_eff
                                || {1'b0, idx_reg} >= (IDX_W + 1)'(DIRECT_PER_INODE))
                        begin
                            res_status_next = ST_BAD_INDEX;
                        end
                        else
                        begin
                            state_next = S_GET_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SCAN:
            begin
                map_raddr = chk_reg + WORD_AW'(1);
                if (word_rsp.has_zero)
                begin
                    map_we                  = 1'b1;
                    map_valid_next[chk_reg] = 1'b1;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - BLK_W'(1);
                    end
                    res_block_next = {chk_reg, word_rsp.zero_pos};
                    if (cmd_reg == CMD_ALLOC_INO)
                    begin
                        list_we                 = 1'b1;
                        len_we                  = 1'b1;
                        len_wdata               = len_reg + LEN_W'(1);
                        len_valid_next[ino_reg] = 1'b1;
                    end
                    state_next = S_FINISH;
                end
                else if (chk_reg == WORD_AW'(MAP_WORDS - 1))
                begin
                    res_status_next = ST_NO_FREE;
                    res_block_next  = '0;
                    state_next      = S_FINISH;
                end
                else
                begin
                    chk_next = chk_reg + WORD_AW'(1);
                end
            end
            S_MAP_WAIT:
            begin
                if (cmd_reg == CMD_TEST)
                begin
                    res_used_next = word_rsp.bit_val;
                end
                else if (word_rsp.bit_val)
                begin
                    map_we                   = 1'b1;
                    map_valid_next[word_idx] = 1'b1;
                    count_next               = count_reg + BLK_W'(1);
                end
                state_next = S_FINISH;
            end
            S_GET_WAIT:
            begin
                res_block_next = list_rdata;
                state_next     = S_FINISH;
            end
            S_FA_WAIT:
            begin
                blk_next  = list_rdata;
                map_raddr = list_rdata[BLK_W-1 -: WORD_AW];
                if (block_ok(list_rdata))
                begin
                    state_next = S_FA_MAP_WAIT;
                end
                else if (fa_last)
                begin
                    len_we                  = 1'b1;
                    len_valid_next[ino_reg] = 1'b1;
                    state_next              = S_FINISH;
                end
                else
                begin
                    iter_next  = iter_reg + LEN_W'(1);
                    list_raddr = base_reg + LIST_AW'(iter_reg) + LIST_AW'(1);
                end
            end
            S_FA_MAP_WAIT:
            begin
                if (word_rsp.bit_val)
                begin
                    map_we                   = 1'b1;
                    map_valid_next[word_idx] = 1'b1;
                    count_next               = count_reg + BLK_W'(1);
                end
                if (fa_last)
                begin
                    len_we                  = 1'b1;
                    len_valid_next[ino_reg] = 1'b1;
                    state_next              = S_FINISH;
                end
                else
                begin
                    iter_next  = iter_reg + LEN_W'(1);
                    list_raddr = base_reg + LIST_AW'(iter_reg) + LIST_AW'(1);
                    state_next = S_FA_WAIT;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    block_next     = res_block_reg;
                    used_next      = res_used_reg;
                    free_next      = count_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= BLK_W'(NUM_BLOCKS - 1);
            out_valid_reg <= 1'b0;
            map_valid_reg <= '0;
            len_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            map_valid_reg <= map_valid_next;
            len_valid_reg <= len_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        blk_reg        <= blk_next;
        ino_reg        <= ino_next;
        inuse_reg      <= inuse_next;
        idx_reg        <= idx_next;
        base_reg       <= base_next;
        len_reg        <= len_next;
        chk_reg        <= chk_next;
        iter_reg       <= iter_next;
        res_status_reg <= res_status_next;
        res_block_reg  <= res_block_next;
        res_used_reg   <= res_used_next;
        status_reg     <= status_next;
        block_reg      <= block_next;
        used_reg       <= used_next;
        free_reg       <= free_next;
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while sequencer did not go busy");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_FINISH))
        else $error("result appeared outside the finish step");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_BAD_INDEX))
        else $error("result carries an undefined status code");

    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && word_rsp.has_zero && (count_reg != '0)
        |=> count_reg == $past(count_reg) - BLK_W'(1))
        else $error("allocation did not decrement the free count");
`endif

endmodule

// File: design/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/bba_word_unit.sv
// Shared bitmap word unit: lowest-zero search, bit test and bit update.
module bba_word_unit
    import bba_pkg::*;
(
    input  word_req_t req,
    output word_rsp_t rsp
);

    always_comb
    begin
        logic              found;
        logic [BIT_AW-1:0] zpos;
        logic [BIT_AW-1:0] target;
        found = 1'b0;
        zpos  = '0;
        for (int i = MAP_BITS - 1; i >= 0; i--)
        begin
            if (!req.word[i])
            begin
                found = 1'b1;
                zpos  = BIT_AW'(i);
            end
        end
        target           = req.find_zero ? zpos : req.pos;
        rsp.has_zero     = found;
        rsp.zero_pos     = zpos;
        rsp.bit_val      = req.word[req.pos];
        rsp.new_word     = req.word;
        rsp.new_word[target] = req.set_val;
    end

endmodule
